/* hdl/mtb_pkg.sv */
package mtb_pkg;

    // operation codes on the request channel
    localparam logic [2:0] MODE_TICK   = 3'd0;
    localparam logic [2:0] MODE_ALLOC  = 3'd1;
    localparam logic [2:0] MODE_START  = 3'd2;
    localparam logic [2:0] MODE_STOP   = 3'd3;
    localparam logic [2:0] MODE_STATUS = 3'd4;

    // response kinds
    localparam logic [1:0] KIND_EVENT  = 2'd0;
    localparam logic [1:0] KIND_ALLOC  = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;
    localparam logic [1:0] KIND_ACK    = 2'd3;

    // events per tick are capped
    localparam int MAX_EVENTS = 16;
    localparam int NEV_W      = 5;

    typedef struct packed {
        logic [2:0]  mode;
        logic [3:0]  timer_id;
        logic [31:0] period_ticks;
        logic        repeat_req;
        logic        notify;
    } t_req;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] result_id;
        logic       is_running;
        logic       has_expired;
        logic       accepted;
        logic       last;
    } t_rsp;

    // outcome of one timer update
    typedef struct packed {
        logic fire;
        logic expire;
    } t_cnt_flags;

endpackage

/* hdl/mtb_ram.sv */
module mtb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/mtb_cnt_unit.sv */
// Shared count/compare unit: one timer per use.
module mtb_cnt_unit #(
    parameter int TICK_WIDTH = 32
) (
    input  logic [TICK_WIDTH-1:0] i_count,
    input  logic [TICK_WIDTH-1:0] i_period,
    input  logic                  i_periodic,
    output mtb_pkg::t_cnt_flags   o_flags,
    output logic [TICK_WIDTH-1:0] o_count
);

    logic w_below;

    assign w_below        = i_count < i_period;
    assign o_flags.fire   = !w_below;
    assign o_flags.expire = !w_below && !i_periodic;

    always_comb begin
        if (w_below) begin
            o_count = i_count + TICK_WIDTH'(1);
        end else if (i_periodic) begin
            o_count = '0;
        end else begin
            o_count = i_count;
        end
    end

endmodule

/* hdl/multi_timer_bank.sv */
// Channel    Dir  Handshake                  Payload
// request    in   i_req_valid / o_req_stall  i_req (mtb_pkg::t_req)
// response   out  o_rsp_valid / i_rsp_stall  o_rsp (mtb_pkg::t_rsp)
//
// Allocate, start, stop and status are accepted, then decoded into the
//   response register. Unknown modes return to idle with no response.
// Tick walks the K ids in use (reserved id 0 included) one at a time through
//   the shared count unit: one RAM read, then one update per timer.
// Reset (i_rst_n low, synchronous) clears flags and control, and sets the id allocator to 1.
// A stalled response holds the sequencer only when a new one has to be loaded.
module multi_timer_bank #(
    parameter int NUM_TIMERS = 16,
    parameter int TICK_WIDTH = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_stall,
    input  mtb_pkg::t_req i_req,
    output logic          o_rsp_valid,
    input  logic          i_rsp_stall,
    output mtb_pkg::t_rsp o_rsp
);

    localparam int IW = $clog2(NUM_TIMERS);      // timer index
    localparam int CW = $clog2(NUM_TIMERS + 1);  // id count, holds NUM_TIMERS
    localparam int TW = TICK_WIDTH;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;  // decode / single-response ops
    localparam logic [2:0] S_RD   = 3'd2;  // RAM read of timer r_idx
    localparam logic [2:0] S_EV   = 3'd3;  // update timer r_idx
    localparam logic [2:0] S_END  = 3'd4;  // flush held event with last set

    logic [2:0]            r_state,     n_state;
    mtb_pkg::t_req         r_req,       n_req;
    logic                  r_out_valid, n_out_valid;
    mtb_pkg::t_rsp         r_out,       n_out;
    logic [NUM_TIMERS-1:0] r_run,       n_run;
    logic [NUM_TIMERS-1:0] r_exp,       n_exp;
    logic [NUM_TIMERS-1:0] r_prd,       n_prd;
    logic [NUM_TIMERS-1:0] r_ntf,       n_ntf;
    logic [CW-1:0]         r_ids,       n_ids;
    logic [CW-1:0]         r_idx,       n_idx;
    logic [mtb_pkg::NEV_W-1:0] r_nev,   n_nev;
    // The last flag is only known at the end of the scan, so each event is
    // held here until the next one (or the end of the scan) releases it.
    logic                  r_pend_v,    n_pend_v;
    logic [3:0]            r_pend_id,   n_pend_id;

    // period/count RAM: {period, count} per timer
    logic                  w_we;
    logic [IW-1:0]         w_waddr;
    logic [2*TW-1:0]       w_wdata;
    logic [2*TW-1:0]       w_rdata;

    logic [IW-1:0]         w_ix;
    logic [IW-1:0]         w_id_ix;
    logic                  w_inbank;
    logic                  w_allocated;
    logic [TW-1:0]         w_per;
    logic [TW-1:0]         w_rd_period;
    logic [TW-1:0]         w_rd_count;
    logic [TW-1:0]         w_new_count;
    mtb_pkg::t_cnt_flags   w_cnt;
    logic                  w_out_free;
    logic                  w_active;
    logic                  w_emit;

    assign w_ix        = r_idx[IW-1:0];
    assign w_id_ix     = IW'(r_req.timer_id);
    assign w_inbank    = int'(r_req.timer_id) < NUM_TIMERS;
    assign w_allocated = int'(r_req.timer_id) < int'(r_ids);
    assign w_per       = TW'(r_req.period_ticks);
    assign w_rd_period = w_rdata[2*TW-1:TW];
    assign w_rd_count  = w_rdata[TW-1:0];
    assign w_out_free  = !r_out_valid || !i_rsp_stall;
    // running implies not expired in practice; both checked as the scan rule says
    assign w_active    = r_run[w_ix] && !r_exp[w_ix];
    assign w_emit      = w_active && w_cnt.fire && r_ntf[w_ix]
                         && (r_nev < mtb_pkg::NEV_W'(mtb_pkg::MAX_EVENTS));

    // Entries are used only for running timers, and start writes the entry
    // in the same cycle that it sets running, so the RAM needs no clearing.
    mtb_ram #(
        .WIDTH (2 * TW),
        .DEPTH (NUM_TIMERS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_ix),
        .o_rdata (w_rdata)
    );

    mtb_cnt_unit #(
        .TICK_WIDTH (TW)
    ) u_cnt (
        .i_count    (w_rd_count),
        .i_period   (w_rd_period),
        .i_periodic (r_prd[w_ix]),
        .o_flags    (w_cnt),
        .o_count    (w_new_count)
    );

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_run       = r_run;
        n_exp       = r_exp;
        n_prd       = r_prd;
        n_ntf       = r_ntf;
        n_ids       = r_ids;
        n_idx       = r_idx;
        n_nev       = r_nev;
        n_pend_v    = r_pend_v;
        n_pend_id   = r_pend_id;
        w_we        = 1'b0;
        w_waddr     = w_id_ix;
        w_wdata     = {w_per, {TW{1'b0}}};

        if (r_out_valid && !i_rsp_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_req   = i_req;
                    n_state = S_DEC;
                end
            end

            S_DEC: begin
                case (r_req.mode)
                    mtb_pkg::MODE_TICK: begin
                        n_idx    = '0;
                        n_nev    = '0;
                        n_pend_v = 1'b0;
                        n_state  = S_RD;
                    end
                    mtb_pkg::MODE_ALLOC: begin
                        if (w_out_free) begin
                            n_out_valid = 1'b1;
                            if (int'(r_ids) >= NUM_TIMERS) begin
                                n_out = '{kind: mtb_pkg::KIND_ALLOC, result_id: 4'd0,
                                          is_running: 1'b0, has_expired: 1'b0,
                                          accepted: 1'b0, last: 1'b1};
                            end else begin
                                n_out = '{kind: mtb_pkg::KIND_ALLOC,
                                          result_id: 4'(r_ids),
                                          is_running: 1'b0, has_expired: 1'b0,
                                          accepted: 1'b1, last: 1'b1};
                                n_ids = r_ids + CW'(1);
                            end
                            n_state = S_IDLE;
                        end
                    end
                    mtb_pkg::MODE_START: begin
                        if (w_out_free) begin
                            n_out_valid = 1'b1;
                            n_out = '{kind: mtb_pkg::KIND_ACK,
                                      result_id: r_req.timer_id,
                                      is_running: 1'b0, has_expired: 1'b0,
                                      accepted: w_inbank && w_allocated, last: 1'b1};
                            if (w_inbank && w_allocated) begin
                                w_we           = 1'b1;
                                n_prd[w_id_ix] = r_req.repeat_req;
                                n_exp[w_id_ix] = 1'b0;
                                n_ntf[w_id_ix] = r_req.notify;
                                n_run[w_id_ix] = 1'b1;
                            end
                            n_state = S_IDLE;
                        end
                    end
                    mtb_pkg::MODE_STOP: begin
                        if (w_out_free) begin
                            n_out_valid = 1'b1;
                            n_out = '{kind: mtb_pkg::KIND_ACK,
                                      result_id: r_req.timer_id,
                                      is_running: 1'b0, has_expired: 1'b0,
                                      accepted: w_inbank, last: 1'b1};
                            // period/count are dead until the next start rewrites them
                            if (w_inbank) begin
                                n_run[w_id_ix] = 1'b0;
                                n_exp[w_id_ix] = 1'b1;
                                n_ntf[w_id_ix] = 1'b0;
                            end
                            n_state = S_IDLE;
                        end
                    end
                    mtb_pkg::MODE_STATUS: begin
                        if (w_out_free) begin
                            n_out_valid = 1'b1;
                            n_out = '{kind: mtb_pkg::KIND_STATUS,
                                      result_id: r_req.timer_id,
                                      is_running: w_inbank && r_run[w_id_ix],
                                      has_expired: w_inbank && !r_prd[w_id_ix]
                                                   && r_exp[w_id_ix],
                                      accepted: 1'b0, last: 1'b1};
                            n_state = S_IDLE;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end

            S_RD: begin
                if (r_idx == r_ids) begin
                    n_state = S_END;
                end else begin
                    n_state = S_EV;
                end
            end

            S_EV: begin
                // a second event needs the response register to push the held one
                if (!(w_emit && r_pend_v && !w_out_free)) begin
                    if (w_active) begin
                        w_we    = 1'b1;
                        w_waddr = w_ix;
                        w_wdata = {w_rd_period, w_new_count};
                        if (w_cnt.expire) begin
                            n_exp[w_ix] = 1'b1;
                            n_run[w_ix] = 1'b0;
                        end
                    end
                    if (w_emit) begin
                        if (r_pend_v) begin
                            n_out_valid = 1'b1;
                            n_out = '{kind: mtb_pkg::KIND_EVENT, result_id: r_pend_id,
                                      is_running: 1'b0, has_expired: 1'b0,
                                      accepted: 1'b0, last: 1'b0};
                        end
                        n_pend_v  = 1'b1;
                        n_pend_id = 4'(r_idx);
                        n_nev     = r_nev + mtb_pkg::NEV_W'(1);
                    end
                    n_idx   = r_idx + CW'(1);
                    n_state = S_RD;
                end
            end

            S_END: begin
                if (!r_pend_v) begin
                    n_state = S_IDLE;
                end else if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out = '{kind: mtb_pkg::KIND_EVENT, result_id: r_pend_id,
                              is_running: 1'b0, has_expired: 1'b0,
                              accepted: 1'b0, last: 1'b1};
                    n_pend_v = 1'b0;
                    n_state  = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_run       <= '0;
            r_exp       <= '0;
            r_prd       <= '0;
            r_ntf       <= '0;
            r_ids       <= CW'(1);
            r_idx       <= '0;
            r_nev       <= '0;
            r_pend_v    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_run       <= n_run;
            r_exp       <= n_exp;
            r_prd       <= n_prd;
            r_ntf       <= n_ntf;
            r_ids       <= n_ids;
            r_idx       <= n_idx;
            r_nev       <= n_nev;
            r_pend_v    <= n_pend_v;
        end
        r_req     <= n_req;
        r_out     <= n_out;
        r_pend_id <= n_pend_id;
    end

    assign o_req_stall = (r_state != S_IDLE);
    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

    // id allocator stays within 1..NUM_TIMERS
    a_ids_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ids != '0) && (int'(r_ids) <= NUM_TIMERS))
        else $error("id allocator out of range");

    // a timer is never both running and expired
    a_run_exp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_run & r_exp) == '0)
        else $error("timer running and expired at once");

    // event cap per tick
    a_nev_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_nev) <= mtb_pkg::MAX_EVENTS)
        else $error("event count above cap");

    // a held event exists only during a tick scan
    a_pend_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_v |-> (r_state == S_RD || r_state == S_EV || r_state == S_END))
        else $error("held event outside tick scan");

    // the scan index never passes the allocated range
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EV) |-> (r_idx < r_ids))
        else $error("scan index past allocated ids");

endmodule
